>>> rtl/arpc_pkg.sv
package arpc_pkg;

  localparam int unsigned ENTRIES = 128;
  localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam int unsigned IP_W    = 32;
  localparam int unsigned MAC_W   = 48;
  localparam int unsigned TICK_W  = 32;
  localparam int unsigned ETYPE_W = 16;
  localparam int unsigned OPC_W   = 16;
  localparam int unsigned MODE_W  = 2;

  localparam logic [MODE_W-1:0]  MODE_TICK   = 2'd0;
  localparam logic [MODE_W-1:0]  MODE_LOOKUP = 2'd1;
  localparam logic [MODE_W-1:0]  MODE_FRAME  = 2'd2;

  localparam logic [ETYPE_W-1:0] ARP_ETHERTYPE = 16'h0806;
  localparam logic [OPC_W-1:0]   ARP_OP_REPLY  = 16'd2;
  localparam logic [TICK_W-1:0]  EXPIRY_RESET  = 32'd300;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_TICK,
    OP_LOOKUP,
    OP_STORE
  } op_e;

  typedef struct packed {
    logic              valid;
    logic [IP_W-1:0]   ip;
    logic [MAC_W-1:0]  mac;
    logic [TICK_W-1:0] birth;
  } entry_t;

endpackage

>>> rtl/arpc_cell.sv
module arpc_cell import arpc_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   shift_i,
  input  entry_t entry_i,
  output entry_t entry_o
);

  logic              valid_q;
  logic [IP_W-1:0]   ip_q;
  logic [MAC_W-1:0]  mac_q;
  logic [TICK_W-1:0] birth_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= entry_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      ip_q    <= entry_i.ip;
      mac_q   <= entry_i.mac;
      birth_q <= entry_i.birth;
    end
  end

  assign entry_o = '{valid: valid_q, ip: ip_q, mac: mac_q, birth: birth_q};

endmodule

>>> rtl/arpc_scan.sv
module arpc_scan import arpc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [MODE_W-1:0]  mode_i,
  input  logic [IP_W-1:0]    ip_addr_i,
  input  logic [MAC_W-1:0]   mac_addr_i,
  input  logic [ETYPE_W-1:0] ether_type_i,
  input  logic [OPC_W-1:0]   arp_opcode_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [TICK_W-1:0]  cfg_data_i,
  input  entry_t             head_i,
  output entry_t             tail_o,
  output logic               shift_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               found_o,
  output logic [MAC_W-1:0]   mac_out_o,
  output logic               stored_o,
  output logic               table_full_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [IDX_W-1:0]  step_q, step_d;
  op_e               op_q, op_d;
  logic [IP_W-1:0]   ip_q;
  logic [MAC_W-1:0]  mac_q;
  logic [TICK_W-1:0] tick_q, tick_d;
  logic [TICK_W-1:0] expiry_q;
  logic              found_q, found_d;
  logic [MAC_W-1:0]  hit_mac_q, hit_mac_d;
  logic              stored_q, stored_d;
  logic              out_valid_q;
  logic              out_found_q, out_stored_q, out_full_q;
  logic [MAC_W-1:0]  out_mac_q;
  logic              in_fire, last_step, out_free, load_out;
  logic [TICK_W-1:0] age;
  logic              res_found, res_stored;
  logic [MAC_W-1:0]  res_mac;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign shift_o     = (state_q == ST_SCAN);
  assign last_step   = (step_q == IDX_W'(ENTRIES - 1));
  assign out_free    = !out_valid_q || out_ready_i;
  assign age         = tick_q - head_i.birth;

  always_comb begin
    case (mode_i)
      MODE_TICK:   op_d = OP_TICK;
      MODE_LOOKUP: op_d = OP_LOOKUP;
      MODE_FRAME:  op_d = (ether_type_i == ARP_ETHERTYPE && arp_opcode_i == ARP_OP_REPLY)
                          ? OP_STORE : OP_NONE;
      default:     op_d = OP_NONE;
    endcase
  end

  always_comb begin
    tail_o    = head_i;
    found_d   = found_q;
    hit_mac_d = hit_mac_q;
    stored_d  = stored_q;
    case (op_q)
      OP_TICK: begin
        if (head_i.valid && age >= expiry_q) begin
          tail_o.valid = 1'b0;
        end
      end
      OP_LOOKUP: begin
        if (!found_q && head_i.valid && head_i.ip == ip_q) begin
          found_d   = 1'b1;
          hit_mac_d = head_i.mac;
        end
      end
      OP_STORE: begin
        if (!stored_q && !head_i.valid) begin
          tail_o   = '{valid: 1'b1, ip: ip_q, mac: mac_q, birth: tick_q};
          stored_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_SCAN;
          step_d  = '0;
        end
      end
      ST_SCAN: begin
        step_d = step_q + IDX_W'(1);
        if (last_step) begin
          state_d = out_free ? ST_IDLE : ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign load_out   = ((state_q == ST_SCAN) && last_step && out_free) ||
                      ((state_q == ST_HOLD) && out_free);
  assign res_found  = shift_o ? found_d   : found_q;
  assign res_mac    = shift_o ? hit_mac_d : hit_mac_q;
  assign res_stored = shift_o ? stored_d  : stored_q;
  assign tick_d     = (in_fire && op_d == OP_TICK) ? tick_q + TICK_W'(1) : tick_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      op_q        <= OP_NONE;
      tick_q      <= '0;
      expiry_q    <= EXPIRY_RESET;
      found_q     <= 1'b0;
      stored_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      tick_q  <= tick_d;
      if (cfg_valid_i && cfg_ready_o) begin
        expiry_q <= cfg_data_i;
      end
      if (in_fire) begin
        op_q     <= op_d;
        found_q  <= 1'b0;
        stored_q <= 1'b0;
      end else if (shift_o) begin
        found_q  <= found_d;
        stored_q <= stored_d;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ip_q      <= ip_addr_i;
      mac_q     <= mac_addr_i;
      hit_mac_q <= '0;
    end else if (shift_o) begin
      hit_mac_q <= hit_mac_d;
    end
    if (load_out) begin
      out_found_q  <= res_found;
      out_mac_q    <= res_found ? res_mac : '0;
      out_stored_q <= res_stored;
      out_full_q   <= (op_q == OP_STORE) && !res_stored;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign found_o      = out_found_q;
  assign mac_out_o    = out_mac_q;
  assign stored_o     = out_stored_q;
  assign table_full_o = out_full_q;

endmodule

>>> rtl/arp_cache_with_aging.sv
// Channel  Handshake                 Word
// in       in_valid_i / in_ready_o   mode, ip_addr, mac_addr, ether_type, arp_opcode
// out      out_valid_o / out_ready_i found, mac_out, stored, table_full
// cfg      cfg_valid_i / cfg_ready_o cfg_data_i (expiry_ticks)
//
// Each word is accepted in the idle state, then makes one full
// rotation of the cell ring past the head, one entry per cycle.
// Reset clears every valid bit, the tick counter, and sets expiry to 300.
// A result waits in the output register; the next word is taken meanwhile,
// and the ring holds after its rotation while the previous result is unread.
module arp_cache_with_aging import arpc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [MODE_W-1:0]  mode_i,
  input  logic [IP_W-1:0]    ip_addr_i,
  input  logic [MAC_W-1:0]   mac_addr_i,
  input  logic [ETYPE_W-1:0] ether_type_i,
  input  logic [OPC_W-1:0]   arp_opcode_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [TICK_W-1:0]  cfg_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               found_o,
  output logic [MAC_W-1:0]   mac_out_o,
  output logic               stored_o,
  output logic               table_full_o
);

  entry_t cell_out [ENTRIES];
  entry_t tail;
  logic   shift;

  for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
    if (k == ENTRIES - 1) begin : g_tail
      arpc_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (shift),
        .entry_i (tail),
        .entry_o (cell_out[k])
      );
    end else begin : g_body
      arpc_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (shift),
        .entry_i (cell_out[k+1]),
        .entry_o (cell_out[k])
      );
    end
  end

  arpc_scan u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .ip_addr_i    (ip_addr_i),
    .mac_addr_i   (mac_addr_i),
    .ether_type_i (ether_type_i),
    .arp_opcode_i (arp_opcode_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .head_i       (cell_out[0]),
    .tail_o       (tail),
    .shift_o      (shift),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .found_o      (found_o),
    .mac_out_o    (mac_out_o),
    .stored_o     (stored_o),
    .table_full_o (table_full_o)
  );

`ifndef SYNTHESIS
  a_accept_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> shift)
    else $error("accepted word did not start a scan");

  a_no_accept_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shift |-> !in_ready_o)
    else $error("input ready during scan");

  a_ring_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !shift |=> $stable(cell_out[0].valid))
    else $error("head entry changed while ring idle");

  a_one_outcome: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(stored_o && table_full_o) && !(found_o && (stored_o || table_full_o)))
    else $error("result carries conflicting flags");
`endif

endmodule

>>> tb/arp_cache_with_aging_checker.sv
`timescale 1ns / 100ps

module arp_cache_with_aging_checker import arpc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [MODE_W-1:0]  mode_i,
  input  logic [IP_W-1:0]    ip_addr_i,
  input  logic [MAC_W-1:0]   mac_addr_i,
  input  logic [ETYPE_W-1:0] ether_type_i,
  input  logic [OPC_W-1:0]   arp_opcode_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [TICK_W-1:0]  cfg_data_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic               found_i,
  input  logic [MAC_W-1:0]   mac_out_i,
  input  logic               stored_i,
  input  logic               table_full_i,
  output int                 outstanding_o,
  output int                 mismatches_o,
  output int                 results_o,
  output int                 hits_o,
  output int                 drops_o
);

  typedef struct packed {
    logic             found;
    logic [MAC_W-1:0] mac;
    logic             stored;
    logic             full;
  } arp_reply_t;

  entry_t            cache_slot [ENTRIES];
  logic [TICK_W-1:0] tick_now;
  logic [TICK_W-1:0] expiry_now;
  arp_reply_t        awaited_replies [$];
  int                mismatch_tally = 0;
  int                result_tally = 0;
  int                hit_tally = 0;
  int                drop_tally = 0;

  assign mismatches_o = mismatch_tally;
  assign results_o    = result_tally;
  assign hits_o       = hit_tally;
  assign drops_o      = drop_tally;

  function automatic arp_reply_t resolve_word(input logic [MODE_W-1:0]  mode,
                                              input logic [IP_W-1:0]    ip,
                                              input logic [MAC_W-1:0]   mac,
                                              input logic [ETYPE_W-1:0] etype,
                                              input logic [OPC_W-1:0]   opcode);
    arp_reply_t        reply;
    logic              done;
    logic [TICK_W-1:0] age;
    reply = '0;
    done  = 1'b0;
    case (mode)
      MODE_TICK: begin
        tick_now = tick_now + TICK_W'(1);
        for (int i = 0; i < ENTRIES; i++) begin
          age = tick_now - cache_slot[i].birth;
          if (cache_slot[i].valid && age >= expiry_now) cache_slot[i].valid = 1'b0;
        end
      end
      MODE_LOOKUP: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (!done && cache_slot[i].valid && cache_slot[i].ip == ip) begin
            reply.found = 1'b1;
            reply.mac   = cache_slot[i].mac;
            done        = 1'b1;
          end
        end
      end
      MODE_FRAME: begin
        if (etype == ARP_ETHERTYPE && opcode == ARP_OP_REPLY) begin
          reply.full = 1'b1;
          for (int i = 0; i < ENTRIES; i++) begin
            if (!done && !cache_slot[i].valid) begin
              cache_slot[i].valid = 1'b1;
              cache_slot[i].ip    = ip;
              cache_slot[i].mac   = mac;
              cache_slot[i].birth = tick_now;
              reply.stored        = 1'b1;
              reply.full          = 1'b0;
              done                = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    return reply;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch on result %0d: %s", result_tally, msg);
    mismatch_tally++;
  endtask

  task automatic check_field(input string name, input logic [MAC_W-1:0] want,
                             input logic [MAC_W-1:0] got);
    if (got !== want) report_mismatch($sformatf("%s expected %0h, got %0h", name, want, got));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    arp_reply_t want;
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) cache_slot[i] = '0;
      tick_now   = '0;
      expiry_now = EXPIRY_RESET;
      awaited_replies.delete();
      outstanding_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) expiry_now = cfg_data_i;
      if (in_valid_i && in_ready_i)
        awaited_replies.push_back(resolve_word(mode_i, ip_addr_i, mac_addr_i,
                                               ether_type_i, arp_opcode_i));
      if (out_valid_i && out_ready_i) begin
        if (awaited_replies.size() == 0) begin
          report_mismatch("result word with nothing expected");
        end else begin
          want = awaited_replies.pop_front();
          check_field("found", 48'(want.found), 48'(found_i));
          check_field("mac_out", want.mac, mac_out_i);
          check_field("stored", 48'(want.stored), 48'(stored_i));
          check_field("table_full", 48'(want.full), 48'(table_full_i));
          if (want.found) hit_tally++;
          if (want.full) drop_tally++;
        end
        result_tally++;
      end
      outstanding_o <= awaited_replies.size();
    end
  end

endmodule

>>> tb/arp_cache_with_aging_test.sv
`timescale 1ns / 100ps

module arp_cache_with_aging_test;
  import arpc_pkg::*;

  localparam logic [MODE_W-1:0]  MODE_UNUSED    = 2'd3;
  localparam logic [OPC_W-1:0]   ARP_OP_REQUEST = 16'd1;
  localparam logic [ETYPE_W-1:0] ETYPE_IPV4     = 16'h0800;
  localparam int STALL_LIMIT = 6000;
  localparam int HOLD_AT     = 450;
  localparam int HOLD_CYCLES = 1000;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE} rx_style_e;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [MODE_W-1:0]  mode = MODE_TICK;
  logic [IP_W-1:0]    ip_addr = '0;
  logic [MAC_W-1:0]   mac_addr = '0;
  logic [ETYPE_W-1:0] ether_type = '0;
  logic [OPC_W-1:0]   arp_opcode = '0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [TICK_W-1:0]  cfg_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               found;
  logic [MAC_W-1:0]   mac_out;
  logic               stored;
  logic               table_full;

  int outstanding;
  int mismatches;
  int results;
  int hits;
  int drops;

  int              words_sent = 0;
  int              cfg_writes = 0;
  int              burst_left = 0;
  int              quiet_cycles = 0;
  logic            hold_done = 1'b0;
  rx_style_e       rx_style;
  int              rx_span;
  logic [IP_W-1:0] known_ips [$];

  arp_cache_with_aging DUT (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .mode_i       (mode),
    .ip_addr_i    (ip_addr),
    .mac_addr_i   (mac_addr),
    .ether_type_i (ether_type),
    .arp_opcode_i (arp_opcode),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .found_o      (found),
    .mac_out_o    (mac_out),
    .stored_o     (stored),
    .table_full_o (table_full)
  );

  arp_cache_with_aging_checker checker_i (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .mode_i        (mode),
    .ip_addr_i     (ip_addr),
    .mac_addr_i    (mac_addr),
    .ether_type_i  (ether_type),
    .arp_opcode_i  (arp_opcode),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_data_i    (cfg_data),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .found_i       (found),
    .mac_out_i     (mac_out),
    .stored_i      (stored),
    .table_full_i  (table_full),
    .outstanding_o (outstanding),
    .mismatches_o  (mismatches),
    .results_o     (results),
    .hits_o        (hits),
    .drops_o       (drops)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  task automatic send_word(input logic [MODE_W-1:0]  m,
                           input logic [IP_W-1:0]    ip,
                           input logic [MAC_W-1:0]   mac,
                           input logic [ETYPE_W-1:0] etype,
                           input logic [OPC_W-1:0]   opcode);
    in_valid   <= 1'b1;
    mode       <= m;
    ip_addr    <= ip;
    mac_addr   <= mac;
    ether_type <= etype;
    arp_opcode <= opcode;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      burst_left = $urandom_range(0, 12);
    end else begin
      burst_left--;
    end
  endtask

  task automatic wait_for_drain;
    do @(posedge clk); while (outstanding != 0);
    repeat (ENTRIES + 4) @(posedge clk);
  endtask

  task automatic write_expiry(input logic [TICK_W-1:0] value);
    wait_for_drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  task automatic offer_random(input int store_pct, input int tick_pct);
    int                 roll;
    logic [IP_W-1:0]    ip;
    logic [MAC_W-1:0]   mac;
    logic [ETYPE_W-1:0] etype;
    logic [OPC_W-1:0]   opcode;
    roll   = $urandom_range(0, 99);
    ip     = $urandom;
    mac    = {16'($urandom), 32'($urandom)};
    etype  = 16'($urandom);
    opcode = 16'($urandom);
    if (roll < store_pct) begin
      if (known_ips.size() > 0 && $urandom_range(0, 3) == 0)
        ip = known_ips[$urandom_range(0, known_ips.size() - 1)];
      known_ips.push_back(ip);
      if (known_ips.size() > 64) void'(known_ips.pop_front());
      send_word(MODE_FRAME, ip, mac, ARP_ETHERTYPE, ARP_OP_REPLY);
    end else if (roll < store_pct + tick_pct) begin
      send_word(MODE_TICK, ip, mac, etype, opcode);
    end else if (roll < 90) begin
      if (known_ips.size() > 0 && $urandom_range(0, 3) != 0)
        ip = known_ips[$urandom_range(0, known_ips.size() - 1)];
      send_word(MODE_LOOKUP, ip, mac, etype, opcode);
    end else begin
      case ($urandom_range(0, 3))
        0:       send_word(MODE_FRAME, ip, mac, ARP_ETHERTYPE, opcode);
        1:       send_word(MODE_FRAME, ip, mac, etype, ARP_OP_REPLY);
        2:       send_word(MODE_FRAME, ip, mac, etype, opcode);
        default: send_word(MODE_UNUSED, ip, mac, etype, opcode);
      endcase
    end
  endtask

  task automatic run_phase(input logic [TICK_W-1:0] expiry, input int words,
                           input int store_pct, input int tick_pct);
    write_expiry(expiry);
    repeat (words) offer_random(store_pct, tick_pct);
    in_valid <= 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(MODE_LOOKUP, '0, '0, '0, '0);
    send_word(MODE_TICK, '1, '1, '1, '1);
    send_word(MODE_FRAME, '0, '0, ARP_ETHERTYPE, ARP_OP_REPLY);
    send_word(MODE_FRAME, '1, '1, ARP_ETHERTYPE, ARP_OP_REPLY);
    send_word(MODE_LOOKUP, '0, '1, '1, '1);
    send_word(MODE_LOOKUP, '1, '0, '0, '0);
    send_word(MODE_FRAME, '0, 48'h0123_4567_89ab, ARP_ETHERTYPE, ARP_OP_REPLY);
    send_word(MODE_LOOKUP, '0, '0, '0, '0);
    send_word(MODE_FRAME, 32'h0a00_0001, '1, ARP_ETHERTYPE, ARP_OP_REQUEST);
    send_word(MODE_FRAME, 32'h0a00_0001, '1, ETYPE_IPV4, ARP_OP_REPLY);
    send_word(MODE_FRAME, '1, '1, '1, '1);
    send_word(MODE_UNUSED, '1, '1, ARP_ETHERTYPE, ARP_OP_REPLY);
    send_word(MODE_UNUSED, '0, '0, '0, '0);
    send_word(MODE_LOOKUP, 32'h0a00_0001, '0, '0, '0);
    send_word(MODE_TICK, '0, '0, '0, '0);
    send_word(MODE_LOOKUP, '1, '0, '0, '0);
    in_valid <= 1'b0;

    // age one tick expires everything
    write_expiry(32'd1);
    send_word(MODE_TICK, '0, '0, '0, '0);
    send_word(MODE_LOOKUP, '0, '0, '0, '0);
    send_word(MODE_FRAME, 32'h1234_5678, 48'hfedc_ba98_7654, ARP_ETHERTYPE, ARP_OP_REPLY);
    send_word(MODE_TICK, '0, '0, '0, '0);
    send_word(MODE_LOOKUP, 32'h1234_5678, '0, '0, '0);
    in_valid <= 1'b0;

    write_expiry(32'd0);
    send_word(MODE_FRAME, 32'h1234_5678, 48'hfedc_ba98_7654, ARP_ETHERTYPE, ARP_OP_REPLY);
    send_word(MODE_LOOKUP, 32'h1234_5678, '0, '0, '0);
    send_word(MODE_TICK, '0, '0, '0, '0);
    send_word(MODE_LOOKUP, 32'h1234_5678, '0, '0, '0);
    in_valid <= 1'b0;

    run_phase(32'hffff_ffff, 260, 60, 5);
    run_phase(32'd6, 130, 35, 25);
    run_phase(EXPIRY_RESET, 90, 40, 10);
    run_phase(32'd1, 60, 40, 25);
    run_phase(32'd40, 150, 40, 25);
    run_phase(32'd0, 40, 40, 25);
    run_phase(32'd3, 70, 35, 30);

    wait_for_drain();
    $display("covered: %0d words in, %0d results compared, %0d lookup hits, %0d drops on full table",
             words_sent, results, hits, drops);
    $display("covered: %0d expiry writes incl. 0, 1, 300 and all ones; one long output stall",
             cfg_writes);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    @(posedge rst_n);
    forever begin
      rx_style = rx_style_e'($urandom_range(0, 2));
      rx_span  = $urandom_range(10, 300);
      repeat (rx_span) begin
        @(posedge clk);
        if (!hold_done && words_sent >= HOLD_AT) begin
          // hold off long enough to back the block up to its input
          out_ready <= 1'b0;
          hold_done = 1'b1;
          repeat (HOLD_CYCLES) @(posedge clk);
        end else begin
          case (rx_style)
            RX_OPEN: out_ready <= 1'b1;
            RX_COIN: out_ready <= 1'($urandom_range(0, 1));
            default: out_ready <= ($urandom_range(0, 5) == 0);
          endcase
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                 quiet_cycles, outstanding);
        $display("status: fail");
        $finish;
      end
    end
  end

endmodule

>>> files.f
rtl/arpc_pkg.sv
rtl/arpc_cell.sv
rtl/arpc_scan.sv
rtl/arp_cache_with_aging.sv
tb/arp_cache_with_aging_checker.sv
tb/arp_cache_with_aging_test.sv
